### rtl/core/polyline_prefix_length_bounds_macros.svh
// Assertion macros shared by the polyline length and bounds core.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef POLYLINE_PREFIX_LENGTH_BOUNDS_MACROS_SVH
`define POLYLINE_PREFIX_LENGTH_BOUNDS_MACROS_SVH

// Check that a property holds in the same cycle as its trigger.
`define PLPLB_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Check that a property holds in the cycle after its trigger.
`define PLPLB_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/plpl_bounds_pkg.sv
// Shared types and constants of the polyline length and bounds core.
// Used by the queue, front, back and top level; depends on nothing.
package plpl_bounds_pkg;

  typedef logic signed [31:0] coord_t;

  localparam int COORD_W          = 32;
  localparam int NUM_AXES         = 4;
  localparam int DEFAULT_MAX_DIMS = 4;
  localparam int DIMS_W           = 3;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd2;

  localparam int SEG_W      = 33;
  localparam int ARC_W      = 48;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int RAD_W      = SQ_W + 2;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int REM_W      = SEG_W + 2;
  localparam int CNT_W      = 6;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Fill state of the queue between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQR  = 6'b000010,
    S_SUM1 = 6'b000100,
    S_SUM2 = 6'b001000,
    S_ROOT = 6'b010000,
    S_DONE = 6'b100000
  } back_state_t;

endpackage

### rtl/core/plpl_bounds_queue.sv
// Short register queue that decouples the front end from the back end.
// Depends on plpl_bounds_pkg and the shared assertion macros.
`include "polyline_prefix_length_bounds_macros.svh"

module plpl_bounds_queue
  import plpl_bounds_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wr_data,
  input  logic         rd,
  output logic [W-1:0] rd_data,
  output q_status_t    stat
);

  logic [W-1:0]      entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = entries[rd_ptr];

  // Storage of the waiting words.
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + QCNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `PLPLB_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))
  `PLPLB_ASSERT_NOW(a_no_write_full, clk, rst, stat.full && !rd, !wr)

endmodule

### rtl/core/plpl_bounds_front.sv
// Front end: accepts vertices, classifies curve starts, forms axis distances.
// Depends on plpl_bounds_pkg; feeds plpl_bounds_queue.
module plpl_bounds_front
  import plpl_bounds_pkg::*;
#(
  parameter int MAX_DIMS = DEFAULT_MAX_DIMS,
  localparam int ENTRY_W = 1 + 2 * COORD_W * MAX_DIMS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [MAX_DIMS-1:0] active,
  input  logic               push,
  input  logic               new_curve,
  input  coord_t             coords [NUM_AXES],
  input  q_status_t          q_stat,
  output logic               q_wr,
  output logic [ENTRY_W-1:0] q_data
);

  logic   have_vertex;
  coord_t prev [MAX_DIMS];
  logic   start;

  assign q_wr  = push && !q_stat.full;
  assign start = new_curve || !have_vertex;
  assign q_data[ENTRY_W-1] = start;

  // Per-axis magnitude of the step from the previous vertex.
  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_axis
    logic signed [COORD_W:0] diff;
    logic signed [COORD_W:0] neg;
    logic [COORD_W-1:0]      mag;

    assign diff = {coords[i][COORD_W-1], coords[i]} - {prev[i][COORD_W-1], prev[i]};
    assign neg  = -diff;
    assign mag  = diff[COORD_W] ? neg[COORD_W-1:0] : diff[COORD_W-1:0];

    assign q_data[(MAX_DIMS + i) * COORD_W +: COORD_W] = coords[i];
    assign q_data[i * COORD_W +: COORD_W] = active[i] ? mag : '0;

    always_ff @(posedge clk) begin
      if (rst) begin
        prev[i] <= '0;
      end else if (q_wr) begin
        prev[i] <= coords[i];
      end
    end
  end

  // A vertex has been seen once the first word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_vertex <= 1'b0;
    end else if (q_wr) begin
      have_vertex <= 1'b1;
    end
  end

endmodule

### rtl/core/plpl_bounds_back.sv
// Back end: squares, sums, digit-serial square root, arc length and box update.
// Depends on plpl_bounds_pkg and the shared assertion macros.
`include "polyline_prefix_length_bounds_macros.svh"

module plpl_bounds_back
  import plpl_bounds_pkg::*;
#(
  parameter int MAX_DIMS = DEFAULT_MAX_DIMS,
  localparam int ENTRY_W = 1 + 2 * COORD_W * MAX_DIMS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [MAX_DIMS-1:0] active,
  input  logic [ENTRY_W-1:0] q_data,
  input  q_status_t          q_stat,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [SEG_W-1:0]   segment_length,
  output logic [ARC_W-1:0]   arc_length,
  output coord_t             low  [NUM_AXES],
  output coord_t             high [NUM_AXES]
);

  back_state_t state;
  back_state_t state_next;

  logic               start_q;
  coord_t             crd [MAX_DIMS];
  logic [COORD_W-1:0] mag [MAX_DIMS];
  logic [SQ_W-1:0]    sq_pad [NUM_AXES];
  logic [SQ_W:0]      pair0;
  logic [SQ_W:0]      pair1;
  logic [RAD_W-1:0]   rad;
  logic [REM_W-1:0]   rem;
  logic [SEG_W-1:0]   root;
  logic [CNT_W-1:0]   cnt;

  logic [ARC_W-1:0]   running;
  coord_t             box_min [MAX_DIMS];
  coord_t             box_max [MAX_DIMS];

  logic               out_valid;
  logic [SEG_W-1:0]   seg_out;
  logic [ARC_W-1:0]   arc_out;

  logic               load;
  logic [REM_W+1:0]   rem_t;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   rem_sub;
  logic               take;
  logic [ARC_W:0]     arc_sum;
  logic [ARC_W-1:0]   running_next;

  assign q_pop = (state == S_IDLE) && !q_stat.empty;
  assign load  = (state == S_DONE) && (!out_valid || pop);
  assign empty = !out_valid;
  assign segment_length = seg_out;
  assign arc_length     = arc_out;

  // One root digit per cycle: bring down two radicand bits, try to subtract.
  assign rem_t   = {rem, rad[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign rem_sub = rem_t - trial;
  assign take    = (rem_t >= trial);

  // Saturating running length; a curve start restarts it at zero.
  assign arc_sum = {1'b0, running} + (ARC_W + 1)'(root);
  always_comb begin
    if (start_q) begin
      running_next = '0;
    end else if (arc_sum[ARC_W]) begin
      running_next = '1;
    end else begin
      running_next = arc_sum[ARC_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          state_next = q_data[ENTRY_W-1] ? S_DONE : S_SQR;
        end
      end
      S_SQR:  state_next = S_SUM1;
      S_SUM1: state_next = S_SUM2;
      S_SUM2: state_next = S_ROOT;
      S_ROOT: begin
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-axis capture, square and box tracking.
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    if (i < MAX_DIMS) begin : g_on
      logic [SQ_W-1:0] prod;
      coord_t          min_new;
      coord_t          max_new;
      coord_t          low_q;
      coord_t          high_q;

      assign sq_pad[i] = prod;
      assign low[i]    = low_q;
      assign high[i]   = high_q;
      assign min_new   = (start_q || (crd[i] < box_min[i])) ? crd[i] : box_min[i];
      assign max_new   = (start_q || (crd[i] > box_max[i])) ? crd[i] : box_max[i];

      always_ff @(posedge clk) begin
        if (q_pop) begin
          crd[i] <= q_data[(MAX_DIMS + i) * COORD_W +: COORD_W];
          mag[i] <= q_data[i * COORD_W +: COORD_W];
        end
        if (state == S_SQR) begin
          prod <= mag[i] * mag[i];
        end
        if (load) begin
          low_q  <= active[i] ? min_new : '0;
          high_q <= active[i] ? max_new : '0;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          box_min[i] <= '0;
          box_max[i] <= '0;
        end else if (load) begin
          box_min[i] <= min_new;
          box_max[i] <= max_new;
        end
      end
    end else begin : g_off
      assign sq_pad[i] = '0;
      assign low[i]    = '0;
      assign high[i]   = '0;
    end
  end

  // Sum of squares and the root datapath.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      start_q <= q_data[ENTRY_W-1];
      root    <= '0;
    end
    if (state == S_SUM1) begin
      pair0 <= {1'b0, sq_pad[0]} + {1'b0, sq_pad[1]};
      pair1 <= {1'b0, sq_pad[2]} + {1'b0, sq_pad[3]};
    end
    if (state == S_SUM2) begin
      rad  <= {1'b0, pair0} + {1'b0, pair1};
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end
    if (state == S_ROOT) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= take ? rem_sub[REM_W-1:0] : rem_t[REM_W-1:0];
      root <= {root[SEG_W-2:0], take};
      cnt  <= cnt + CNT_W'(1);
    end
    if (load) begin
      seg_out <= root;
      arc_out <= running_next;
    end
  end

  // Running length and result word holding.
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        running   <= running_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PLPLB_ASSERT_NEXT(a_start_zero, clk, rst, load && start_q, arc_out == '0 && seg_out == '0)
  `PLPLB_ASSERT_NEXT(a_arc_grows, clk, rst, load && !start_q, running >= $past(running))
  `PLPLB_ASSERT_NOW(a_box_order, clk, rst, 1'b1, box_min[0] <= box_max[0])

endmodule

### rtl/core/polyline_prefix_length_bounds.sv
// Polyline segment length, saturating arc length and per-axis bounding box.
// A continuing vertex passes the square, two sum steps and the square root; a curve start skips them.
// The back end handles one vertex at a time; its square root forms one bit per cycle.
// A two-word queue lets the front take vertices while the back is busy.
// Synchronous active-high reset clears control, box and length; dims_in_use resets to 2.
module polyline_prefix_length_bounds
  import plpl_bounds_pkg::*;
#(
  parameter int MAX_DIMS = DEFAULT_MAX_DIMS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIMS_W-1:0] cfg_data,
  input  logic              push,
  output logic              full,
  input  logic              new_curve,
  input  coord_t            coord_0,
  input  coord_t            coord_1,
  input  coord_t            coord_2,
  input  coord_t            coord_3,
  output logic              empty,
  input  logic              pop,
  output logic [SEG_W-1:0]  segment_length,
  output logic [ARC_W-1:0]  arc_length,
  output coord_t            low_0,
  output coord_t            low_1,
  output coord_t            low_2,
  output coord_t            low_3,
  output coord_t            high_0,
  output coord_t            high_1,
  output coord_t            high_2,
  output coord_t            high_3
);

  localparam int ENTRY_W = 1 + 2 * COORD_W * MAX_DIMS;

  logic [DIMS_W-1:0]   dims_in_use;
  logic [DIMS_W-1:0]   dims_eff;
  logic [MAX_DIMS-1:0] active;
  coord_t              coords [NUM_AXES];
  coord_t              low    [NUM_AXES];
  coord_t              high   [NUM_AXES];
  logic                q_wr;
  logic                q_pop;
  logic [ENTRY_W-1:0]  q_wdata;
  logic [ENTRY_W-1:0]  q_rdata;
  q_status_t           q_stat;

  // Configuration register; always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= DIMS_RESET;
    end else if (cfg_valid) begin
      dims_in_use <= cfg_data;
    end
  end

  // Clamp the axis count into 1..MAX_DIMS and expand it to an axis mask.
  always_comb begin
    if (dims_in_use == '0) begin
      dims_eff = DIMS_W'(1);
    end else if (dims_in_use > DIMS_W'(MAX_DIMS)) begin
      dims_eff = DIMS_W'(MAX_DIMS);
    end else begin
      dims_eff = dims_in_use;
    end
  end

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_mask
    assign active[i] = (DIMS_W'(i) < dims_eff);
  end

  assign coords[0] = coord_0;
  assign coords[1] = coord_1;
  assign coords[2] = coord_2;
  assign coords[3] = coord_3;
  assign full      = q_stat.full;

  plpl_bounds_front #(
    .MAX_DIMS (MAX_DIMS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .active    (active),
    .push      (push),
    .new_curve (new_curve),
    .coords    (coords),
    .q_stat    (q_stat),
    .q_wr      (q_wr),
    .q_data    (q_wdata)
  );

  plpl_bounds_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .rd      (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  plpl_bounds_back #(
    .MAX_DIMS (MAX_DIMS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .active         (active),
    .q_data         (q_rdata),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .segment_length (segment_length),
    .arc_length     (arc_length),
    .low            (low),
    .high           (high)
  );

  assign low_0  = low[0];
  assign low_1  = low[1];
  assign low_2  = low[2];
  assign low_3  = low[3];
  assign high_0 = high[0];
  assign high_1 = high[1];
  assign high_2 = high[2];
  assign high_3 = high[3];

endmodule
